// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL; clocked on clk_i, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge out of reset.
`define UQPD_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("uqpd assertion failed");

// Condition must never be true at a clock edge out of reset.
`define UQPD_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("uqpd forbidden condition seen");

`else

`define UQPD_ASSERT(name, prop)
`define UQPD_NEVER(name, cond)

`endif

`endif

// File: rtl/uqpd_pkg.sv
// Types, codes and helpers for the query pair decoder.
`timescale 1ns / 1ps

package uqpd_pkg;

  localparam int unsigned CapW = 9;

  // Result kinds
  localparam logic [1:0] KindKey     = 2'd0;
  localparam logic [1:0] KindValue   = 2'd1;
  localparam logic [1:0] KindPairEnd = 2'd2;

  // Pair status
  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusBadEscape = 2'd1;
  localparam logic [1:0] StatusTooLong   = 2'd2;

  // Escape phases
  localparam logic [1:0] EscNone = 2'd0;
  localparam logic [1:0] EscHigh = 2'd1;
  localparam logic [1:0] EscLow  = 2'd2;

  // Register indexes
  localparam logic CfgKeyCap   = 1'b0;
  localparam logic CfgValueCap = 1'b1;

  // Characters
  localparam logic [7:0] ChNul     = 8'h00;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChEquals  = 8'h3D;
  localparam logic [7:0] ChAmp     = 8'h26;
  localparam logic [7:0] ChSpace   = 8'h20;

  typedef struct packed {
    logic [1:0]      esc;
    logic            in_value;
    logic            pair_open;
    logic            value_seen;
    logic [3:0]      high_nibble;
    logic            hex_bad;
    logic [1:0]      err;
    logic [CapW-1:0] count;
  } state_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] data;
    logic       has_value;
    logic [1:0] status;
  } res_t;

  // Bit 4 set: not a hex digit; else bits 3:0 hold its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    case (c) inside
      [8'h30:8'h39]: d = {1'b0, c[3:0]};
      [8'h61:8'h66],
      [8'h41:8'h46]: d = {1'b0, 4'(c[3:0] + 4'd9)};
      default:       d = 5'h10;
    endcase
    return d;
  endfunction

endpackage

// File: rtl/uqpd_step.sv
// Per-byte decode step: next parse state and optional result beat.
`timescale 1ns / 1ps

module uqpd_step import uqpd_pkg::*; #(
  parameter int unsigned MAX_FIELD_LENGTH = 256
) (
  input  logic [7:0]      ch_i,
  input  logic [CapW-1:0] key_cap_i,
  input  logic [CapW-1:0] value_cap_i,
  input  state_t          state_i,
  output state_t          state_o,
  output res_t            res_o
);

  localparam logic [16:0] MaxLen = 17'(MAX_FIELD_LENGTH);

  logic [CapW-1:0] key_eff, value_eff, cap;
  logic [4:0]      dig;
  logic [7:0]      byte_v;
  logic            emit;
  state_t          nx;
  res_t            res;

  // capacity clamped to the field limit
  assign key_eff   = ({8'd0, key_cap_i} > MaxLen)   ? MaxLen[CapW-1:0] : key_cap_i;
  assign value_eff = ({8'd0, value_cap_i} > MaxLen) ? MaxLen[CapW-1:0] : value_cap_i;
  assign dig       = hex_digit(ch_i);

  always_comb begin
    nx     = state_i;
    res    = '0;
    emit   = 1'b0;
    byte_v = ch_i;
    cap    = nx.in_value ? value_eff : key_eff;

    if (ch_i == ChNul && !state_i.pair_open) begin
      nx.esc     = EscNone;
      nx.hex_bad = 1'b0;
    end else begin
      if (!nx.pair_open) begin
        nx.pair_open = 1'b1;
        if (key_eff == '0 && nx.err == StatusOk) nx.err = StatusTooLong;
      end

      if (ch_i == ChNul || ch_i == ChAmp) begin
        // pair end; an open escape counts as truncated
        if (nx.esc != EscNone && nx.err == StatusOk) nx.err = StatusBadEscape;
        res.valid     = 1'b1;
        res.kind      = KindPairEnd;
        res.has_value = nx.value_seen;
        res.status    = nx.err;
        nx            = '0;
      end else if (ch_i == ChEquals && !nx.in_value) begin
        if (nx.esc != EscNone && nx.err == StatusOk) nx.err = StatusBadEscape;
        nx.esc         = EscNone;
        nx.hex_bad     = 1'b0;
        nx.high_nibble = '0;
        nx.in_value    = 1'b1;
        nx.value_seen  = 1'b1;
        nx.count       = '0;
        if (value_eff == '0 && nx.err == StatusOk) nx.err = StatusTooLong;
      end else begin
        case (nx.esc)
          EscHigh: begin
            nx.high_nibble = dig[3:0];
            nx.hex_bad     = dig[4];
            nx.esc         = EscLow;
          end
          EscLow: begin
            nx.esc = EscNone;
            if (nx.hex_bad || dig[4]) begin
              nx.hex_bad = 1'b0;
              if (nx.err == StatusOk) nx.err = StatusBadEscape;
            end else begin
              byte_v = {nx.high_nibble, dig[3:0]};
              emit   = 1'b1;
            end
          end
          default: begin
            if (ch_i == ChPercent) begin
              nx.esc     = EscHigh;
              nx.hex_bad = 1'b0;
            end else begin
              byte_v = (ch_i == ChPlus) ? ChSpace : ch_i;
              emit   = 1'b1;
            end
          end
        endcase

        if (emit && nx.err == StatusOk) begin
          cap = nx.in_value ? value_eff : key_eff;
          if (({1'b0, nx.count} + 10'd1) >= {1'b0, cap}) begin
            nx.err = StatusTooLong;
          end else begin
            nx.count  = nx.count + 1'b1;
            res.valid = 1'b1;
            res.kind  = nx.in_value ? KindValue : KindKey;
            res.data  = byte_v;
          end
        end
      end
    end
  end

  assign state_o = nx;
  assign res_o   = res;

endmodule

// File: rtl/url_query_pair_decoder_unit.sv
// Top level of the query pair decoder: handshakes, registers and checks.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Query string pair decoder.
// Input channel: one raw query byte per beat on ch_i (in_valid_i, in_stall_o);
// a zero byte ends the query. Output channel: one beat per decoded key or
// value byte, and one pair-end beat carrying has_value_o and status_o
// (out_valid_o, out_stall_i). Bytes that only move the parser (delimiters,
// escape digits, dropped bytes after an error) produce no output beat.
// Config: cfg_we_i writes cfg_data_i into key capacity (index 0) or value
// capacity (index 1); only write while no byte is in flight.
// Path: a byte is held in the input register, decoded by the single
// combinational step and its result lands in the output register.
// Throughput: one byte per cycle while the output is not stalled; the
// input register takes a new byte as its held byte moves on.
// Stall: a held output beat keeps the byte in the input register; the input
// register still takes a new byte whenever it empties the same cycle.
// Reset: parse state cleared, both capacities set to 256, channels empty.
module url_query_pair_decoder_unit import uqpd_pkg::*; #(
  parameter int unsigned MAX_FIELD_LENGTH = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      ch_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      data_o,
  output logic            has_value_o,
  output logic [1:0]      status_o,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CapW-1:0] cfg_data_i
);

  logic            in_valid_q;
  logic [7:0]      ch_q;
  logic            out_valid_q;
  res_t            res_q, res_d;
  state_t          st_q, st_d;
  logic [CapW-1:0] key_cap_q, value_cap_q;
  logic            advance;

  // Byte in the input register moves on when the output slot is free or draining
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_cap_q   <= CapW'(256);
      value_cap_q <= CapW'(256);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgKeyCap:   key_cap_q   <= cfg_data_i;
        CfgValueCap: value_cap_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      ch_q <= ch_i;
    end
  end

  uqpd_step #(
    .MAX_FIELD_LENGTH(MAX_FIELD_LENGTH)
  ) u_step (
    .ch_i       (ch_q),
    .key_cap_i  (key_cap_q),
    .value_cap_i(value_cap_q),
    .state_i    (st_q),
    .state_o    (st_d),
    .res_o      (res_d)
  );

  // Parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_d.valid;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = res_q.kind;
  assign data_o      = res_q.data;
  assign has_value_o = res_q.has_value;
  assign status_o    = res_q.status;

  // No field or error state survives outside an open pair
  `UQPD_NEVER(a_idle_clean, !st_q.pair_open && (st_q.in_value | (|st_q.err) | (|st_q.count)))
  // '=' sets both flags together, pair end clears both
  `UQPD_NEVER(a_value_flags, st_q.in_value != st_q.value_seen)
  // A bad first digit only lives while the second digit is awaited
  `UQPD_NEVER(a_hex_bad_phase, st_q.hex_bad && st_q.esc != EscLow)
  // A stalled output beat never lets the input register advance
  `UQPD_ASSERT(a_stall_holds, (out_valid_q && out_stall_i) |-> !advance)

endmodule
